/* src/wpm_pkg.sv */
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types, constants and register map of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    // default and largest pattern size in bytes
    localparam int MAX_PATTERN_DEFAULT = 32;

    // pattern storage: four 64-bit words of eight bytes each
    localparam int PAT_WORDS  = 4;
    localparam int PAT_WORD_W = 64;
    localparam int LEN_W      = 6;

    // configuration port geometry
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;

    // register indexes (byte address is 8 times the index)
    localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

    // wildcard characters
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    typedef logic [PAT_WORDS-1:0][PAT_WORD_W-1:0] pattern_words_t;

    // input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_byte;
        logic       last_byte;
    } text_item_t;

    // result item
    typedef struct packed {
        logic matches_so_far;
        logic text_done;
    } match_result_t;

endpackage

/* src/wildcard_pattern_matcher_core.sv */
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core
// Streams text bytes against a configured wildcard pattern, one verdict each.
// ----------------------------------------------------------------------------
// data path: a byte passes the input register, then the result register, and
// waits in the input register while the output stalls
// throughput: one byte per cycle while the output does not stall; the column
// update is a combinational pass set by one 34-bit carry chain between the input and result registers
// reset: clears the column, pattern, length and both valid flags
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_core #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // text input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  wpm_pkg::text_item_t             in_data,
    // verdict output
    output logic                            out_valid,
    input  logic                            out_stall,
    output wpm_pkg::match_result_t          out_data,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wpm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [wpm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [wpm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int COL_W = MAX_PATTERN + 1;

    wpm_pkg::pattern_words_t         pattern_words_reg;
    logic [wpm_pkg::LEN_W-1:0]       pattern_length_reg;
    logic [wpm_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic                            cfg_write;

    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    wpm_pkg::text_item_t             s1_data_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    wpm_pkg::match_result_t          out_data_reg;
    logic [COL_W-1:0]                column_reg;
    logic [COL_W-1:0]                column_calc;
    logic                            match_calc;
    logic                            in_xfer;
    logic                            advance;

    // configuration write and read
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[wpm_pkg::CFG_ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_words_reg  <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                wpm_pkg::REG_PAT_0_7:   pattern_words_reg[0] <= pwdata;
                wpm_pkg::REG_PAT_8_15:  pattern_words_reg[1] <= pwdata;
                wpm_pkg::REG_PAT_16_23: pattern_words_reg[2] <= pwdata;
                wpm_pkg::REG_PAT_24_31: pattern_words_reg[3] <= pwdata;
                wpm_pkg::REG_PAT_LEN:   pattern_length_reg <= pwdata[wpm_pkg::LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            wpm_pkg::REG_PAT_0_7:   prdata = pattern_words_reg[0];
            wpm_pkg::REG_PAT_8_15:  prdata = pattern_words_reg[1];
            wpm_pkg::REG_PAT_16_23: prdata = pattern_words_reg[2];
            wpm_pkg::REG_PAT_24_31: prdata = pattern_words_reg[3];
            wpm_pkg::REG_PAT_LEN:
                prdata = {{(wpm_pkg::CFG_DATA_W - wpm_pkg::LEN_W){1'b0}}, pattern_length_reg};
            default:                prdata = '0;
        endcase
    end

    // pipeline handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // column update
    wpm_column_update #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_column (
        .pattern_words  (pattern_words_reg),
        .pattern_length (pattern_length_reg),
        .column         (column_reg),
        .text_byte      (s1_data_reg.text_byte),
        .first_byte     (s1_data_reg.first_byte),
        .column_next    (column_calc),
        .match          (match_calc)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            column_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                column_reg <= column_calc;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg.matches_so_far <= match_calc;
            out_data_reg.text_done      <= s1_data_reg.last_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_column_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(column_reg))
        else $error("column changed without a transfer");

    a_empty_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (pattern_length_reg == '0)) |=> !out_data_reg.matches_so_far)
        else $error("match reported for an empty pattern");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !advance) |=> !out_valid_reg)
        else $error("result repeated after its transfer");

endmodule

/* src/wpm_column_update.sv */
// ----------------------------------------------------------------------------
// wpm_column_update
// Next prefix-match column for one text byte, all pattern positions at once.
// Star runs propagate like a carry chain and are resolved by one wide add.
// ----------------------------------------------------------------------------
module wpm_column_update #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEFAULT
) (
    input  wpm_pkg::pattern_words_t     pattern_words,
    input  logic [wpm_pkg::LEN_W-1:0]   pattern_length,
    input  logic [MAX_PATTERN:0]        column,
    input  logic [7:0]                  text_byte,
    input  logic                        first_byte,
    output logic [MAX_PATTERN:0]        column_next,
    output logic                        match
);

    localparam int COL_W = MAX_PATTERN + 1;
    localparam int IDX_W = $clog2(COL_W);

    logic [wpm_pkg::LEN_W-1:0] len_sat;
    logic [COL_W-1:0]          in_use;
    logic [MAX_PATTERN-1:0]    is_star;
    logic [MAX_PATTERN-1:0]    is_hit;
    logic [MAX_PATTERN-1:0]    lead_star;
    logic [MAX_PATTERN:0]      lead_star_inc;
    logic [MAX_PATTERN-1:0]    lead_mask;
    logic [COL_W-1:0]          init_col;
    logic [COL_W-1:0]          old_col;
    logic [COL_W:0]            gen;
    logic [COL_W:0]            prop;
    logic [COL_W:0]            add_a;
    logic [COL_W:0]            add_sum;
    logic [COL_W:0]            carries;

    // saturate the length to the pattern size
    assign len_sat = (pattern_length > wpm_pkg::LEN_W'(MAX_PATTERN)) ?
                     wpm_pkg::LEN_W'(MAX_PATTERN) : pattern_length;

    // per-position decode of the pattern bytes
    always_comb
    begin
        in_use[0] = 1'b0;
        for (int j = 1; j <= MAX_PATTERN; j++)
        begin
            in_use[j] = (wpm_pkg::LEN_W'(j) <= len_sat);
        end
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            is_star[k] = (pattern_words[k / 8][(k % 8) * 8 +: 8] == wpm_pkg::STAR_BYTE);
            is_hit[k]  = (pattern_words[k / 8][(k % 8) * 8 +: 8] == wpm_pkg::ANY_BYTE) ||
                         (pattern_words[k / 8][(k % 8) * 8 +: 8] == text_byte);
            lead_star[k] = is_star[k] && in_use[k + 1];
        end
    end

    // initial column: position 0 and the run of leading stars
    assign lead_star_inc = {1'b0, lead_star} + {{MAX_PATTERN{1'b0}}, 1'b1};
    assign lead_mask     = lead_star & ~lead_star_inc[MAX_PATTERN-1:0];
    assign init_col      = {lead_mask, 1'b1};
    assign old_col       = first_byte ? init_col : column;

    // generate and propagate terms per position
    always_comb
    begin
        gen  = '0;
        prop = '0;
        for (int j = 1; j <= MAX_PATTERN; j++)
        begin
            if (is_star[j - 1])
            begin
                gen[j]  = old_col[j] && in_use[j];
                prop[j] = in_use[j];
            end
            else
            begin
                gen[j]  = old_col[j - 1] && is_hit[j - 1] && in_use[j];
                prop[j] = 1'b0;
            end
        end
    end

    // carry chain through star runs: carry into bit j+1 is the new bit j
    assign add_a       = gen | prop;
    assign add_sum     = add_a + gen;
    assign carries     = add_sum ^ add_a ^ gen;
    assign column_next = carries[COL_W:1];
    assign match       = column_next[len_sat[IDX_W-1:0]];

endmodule
